[rtl/modular_exponentiation_unit_defines.svh]
// Assertion macros for the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle in reset.
`define MEU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle in reset.
`define MEU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/meu_pkg.sv]
`timescale 1ns / 1ps

package meu_pkg;

	localparam int MOD_WIDTH_DEF = 31;
	localparam int EXP_WIDTH_DEF = 32;

endpackage

[rtl/modular_exponentiation_unit.sv]
// Each item takes a reduction of the base, then a square per exponent bit and a multiply per set
// exponent bit; an exponent or modulus of zero goes straight to the finish state.
// One item in flight; the next is taken only once the sequencer is back in idle. The sequencer
// drives the bit-serial shift-add-reduce multiplier, one multiplier bit a cycle.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n, asynchronous) returns the sequencer to idle and drops out_valid.
`timescale 1ns / 1ps
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit #(
	parameter int MOD_WIDTH = meu_pkg::MOD_WIDTH_DEF,
	parameter int EXP_WIDTH = meu_pkg::EXP_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MOD_WIDTH-1:0] base_value,
	input  logic [EXP_WIDTH-1:0] exponent,
	input  logic [MOD_WIDTH-1:0] modulus,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [MOD_WIDTH-1:0] power_result
);

	import meu_pkg::*;

	localparam int CW = $clog2(MOD_WIDTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_MUL,
		ST_SQR,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        cnt_q;
	logic [MOD_WIDTH-1:0] m_q;
	logic [MOD_WIDTH-1:0] b_q;
	logic [MOD_WIDTH-1:0] acc_q;
	logic [EXP_WIDTH-1:0] e_q;
	logic [MOD_WIDTH-1:0] r_q;
	logic [MOD_WIDTH-1:0] sh_q;
	logic [MOD_WIDTH-1:0] mcand_q;
	logic [MOD_WIDTH-1:0] res_q;

	logic                 running;
	logic                 last_step;
	logic [MOD_WIDTH+1:0] sum;
	logic [MOD_WIDTH+1:0] m1;
	logic [MOD_WIDTH+1:0] m2;
	logic [MOD_WIDTH-1:0] r_next;
	logic [MOD_WIDTH-1:0] nb;
	logic [MOD_WIDTH-1:0] na;
	logic [EXP_WIDTH-1:0] ne;

	assign in_ready  = (state_q == ST_IDLE);
	assign running   = (state_q == ST_REDUCE) || (state_q == ST_MUL) || (state_q == ST_SQR);
	assign last_step = running && (cnt_q == '0);

	// Double, add the selected multiplicand, reduce by at most two moduli.
	always_comb begin
		m1  = {2'b00, m_q};
		m2  = {1'b0, m_q, 1'b0};
		sum = {1'b0, r_q, 1'b0} + (sh_q[MOD_WIDTH-1] ? {2'b00, mcand_q} : '0);
		if (sum >= m2) begin
			r_next = MOD_WIDTH'(sum - m2);
		end else if (sum >= m1) begin
			r_next = MOD_WIDTH'(sum - m1);
		end else begin
			r_next = MOD_WIDTH'(sum);
		end
	end

	always_comb begin
		nb = (state_q == ST_MUL) ? b_q : r_next;
		na = (state_q == ST_MUL) ? r_next : acc_q;
		ne = (state_q == ST_SQR) ? (e_q >> 1) : e_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			out_valid    <= 1'b0;
			power_result <= '0;
		end else begin
			if (out_valid && out_ready && state_q != ST_FINISH) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= CW'(MOD_WIDTH - 1);
						if (exponent == '0 || modulus == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_REDUCE;
						end
					end
				end
				ST_REDUCE, ST_MUL, ST_SQR: begin
					if (last_step) begin
						cnt_q <= CW'(MOD_WIDTH - 1);
						if (state_q == ST_MUL) begin
							state_q <= ST_SQR;
						end else if (ne == '0) begin
							state_q <= ST_FINISH;
						end else if (ne[0]) begin
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_SQR;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FINISH: begin
					if (!out_valid || out_ready) begin
						power_result <= res_q;
						out_valid    <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			m_q     <= modulus;
			e_q     <= exponent;
			acc_q   <= (modulus == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
			r_q     <= '0;
			sh_q    <= base_value;
			mcand_q <= MOD_WIDTH'(1);
			if (exponent == '0) begin
				res_q <= MOD_WIDTH'(1);
			end else begin
				res_q <= '0;
			end
		end else if (running) begin
			if (last_step) begin
				b_q   <= nb;
				acc_q <= na;
				e_q   <= ne;
				r_q   <= '0;
				if (state_q == ST_MUL || ne[0] == 1'b0) begin
					sh_q <= nb;
				end else begin
					sh_q <= na;
				end
				mcand_q <= nb;
				res_q   <= na;
			end else begin
				r_q  <= r_next;
				sh_q <= {sh_q[MOD_WIDTH-2:0], 1'b0};
			end
		end
	end

	`MEU_ASSERT_NOW(a_operands_reduced, (state_q == ST_MUL || state_q == ST_SQR), (b_q < m_q && acc_q < m_q), "operand not reduced below modulus")
	`MEU_ASSERT_NOW(a_partial_reduced, running, (r_q < m_q), "partial product not reduced below modulus")
	`MEU_ASSERT_NEXT(a_step_holds, (running && cnt_q != '0), (state_q == $past(state_q)), "multiply left before its last bit")
	`MEU_ASSERT_NEXT(a_trivial_finish, (in_valid && in_ready && exponent == '0), (state_q == ST_FINISH && res_q == MOD_WIDTH'(1)), "zero exponent did not give one")

endmodule
